### hdl/rmq_pkg.sv
// rmq_pkg: widths, component codes and pipeline stage types for the
// rotation matrix to quaternion converter. No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int DW        = 32;          // data width, Q2.30
    localparam int FW        = DW - 2;      // fraction bits
    localparam int XW        = DW + 3;      // width of exact sums of entries
    localparam int NW        = DW + 1;      // numerator width (sum of two entries)
    localparam int RADW      = DW + 1;      // radicand width, unsigned
    localparam int SW        = DW;          // root width
    localparam int NBITS     = 2 * DW;      // radicand bits fed to the root chain
    localparam int REMW      = DW + 2;      // root chain remainder width
    localparam int DVW       = DW + 1;      // divisor width (2s)
    localparam int QW        = DW - 1;      // quotient bits below the overflow point
    localparam int LANES     = 3;
    localparam int SQ_CELLS  = SW;
    localparam int DIV_CELLS = QW;

    typedef logic [1:0] comp_t;
    localparam comp_t COMP_X = 2'd0;
    localparam comp_t COMP_Y = 2'd1;
    localparam comp_t COMP_Z = 2'd2;
    localparam comp_t COMP_W = 2'd3;

    typedef struct packed {
        logic [LANES-1:0][NW-1:0] num;
        comp_t                    rsel;
    } rmq_meta_t;

    typedef struct packed {
        logic             valid;
        logic [NBITS-1:0] bits;
        logic [REMW-1:0]  rem;
        logic [SW-1:0]    root;
        rmq_meta_t        meta;
    } rmq_sq_t;

    typedef struct packed {
        logic                      valid;
        logic [LANES-1:0][DVW-1:0] rem;
        logic [LANES-1:0][QW-1:0]  quo;
        logic [LANES-1:0]          nb;
        logic [LANES-1:0]          neg;
        logic [LANES-1:0]          ovf;
        logic [DVW-1:0]            dvs;
        logic                      zero;
        logic [SW-1:0]             half;
        comp_t                     rsel;
    } rmq_dv_t;

endpackage

### hdl/rotation_matrix_to_quaternion_top.sv
// Shepperd rotation matrix to quaternion converter, top level.
// Depends on rmq_pkg, rmq_prep, rmq_sqrt_cell, rmq_div_cell.
`timescale 1ns / 1ps

// Accepts one matrix per cycle while stall is low and returns the quaternion
// through one input stage, a chain of 32 root cells (one root bit each), one
// divider setup stage, a chain of 31 divider cells (one quotient bit per lane
// each) and the output register. The whole pipe holds while a finished result
// is stalled, so stall on the input follows quat_stall while quat_valid is high.

module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic signed [DW-1:0] m00,
    input  logic signed [DW-1:0] m01,
    input  logic signed [DW-1:0] m02,
    input  logic signed [DW-1:0] m10,
    input  logic signed [DW-1:0] m11,
    input  logic signed [DW-1:0] m12,
    input  logic signed [DW-1:0] m20,
    input  logic signed [DW-1:0] m21,
    input  logic signed [DW-1:0] m22,
    output logic                 quat_valid,
    input  logic                 quat_stall,
    output logic signed [DW-1:0] quat_x,
    output logic signed [DW-1:0] quat_y,
    output logic signed [DW-1:0] quat_z,
    output logic signed [DW-1:0] quat_w
);

    localparam logic [DW-1:0] MAX_Q = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_Q = {1'b1, {(DW-1){1'b0}}};

    logic en;
    rmq_sq_t sq [0:SQ_CELLS];
    rmq_dv_t dv [0:DIV_CELLS];
    rmq_dv_t dv_entry_reg, dv_entry_next;
    rmq_dv_t dv_last;
    rmq_sq_t sq_last;

    logic [LANES-1:0][NW-1:0] mag;
    logic [LANES-1:0][DW-1:0] lane_val;
    logic [3:0][DW-1:0]       comp_val;
    logic                     out_valid_reg;
    logic [3:0][DW-1:0]       out_reg, out_next;

    assign en    = !(out_valid_reg && quat_stall);
    assign stall = !en;

    rmq_prep u_prep
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (valid),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22),
        .dout     (sq[0])
    );

    for (genvar c = 0; c < SQ_CELLS; c++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (sq[c]),
            .dout  (sq[c+1])
        );
    end

    assign sq_last = sq[SQ_CELLS];

    // divider setup: magnitudes, signs and overflow check against 4s
    always_comb
    begin
        dv_entry_next.valid = sq_last.valid;
        dv_entry_next.dvs   = {sq_last.root, 1'b0};
        dv_entry_next.zero  = (sq_last.root == '0);
        dv_entry_next.half  = {1'b0, sq_last.root[SW-1:1]};
        dv_entry_next.rsel  = sq_last.meta.rsel;
        for (int l = 0; l < LANES; l++)
        begin
            dv_entry_next.neg[l] = sq_last.meta.num[l][NW-1];
            mag[l] = sq_last.meta.num[l][NW-1] ? (NW'(0) - sq_last.meta.num[l])
                                               : sq_last.meta.num[l];
            dv_entry_next.ovf[l] = ({1'b0, mag[l]} >= {sq_last.root, 2'b00});
            dv_entry_next.rem[l] = DVW'(mag[l] >> 1);
            dv_entry_next.nb[l]  = mag[l][0];
            dv_entry_next.quo[l] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_entry_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            dv_entry_reg <= dv_entry_next;
        end
    end

    assign dv[0] = dv_entry_reg;

    for (genvar c = 0; c < DIV_CELLS; c++)
    begin : g_div
        rmq_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (dv[c]),
            .dout  (dv[c+1])
        );
    end

    assign dv_last = dv[DIV_CELLS];

    // saturate each lane and place lanes around the root component
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (dv_last.zero)
            begin
                lane_val[l] = '0;
            end
            else if (dv_last.ovf[l])
            begin
                lane_val[l] = dv_last.neg[l] ? MIN_Q : MAX_Q;
            end
            else if (dv_last.neg[l])
            begin
                lane_val[l] = DW'(0) - {1'b0, dv_last.quo[l]};
            end
            else
            begin
                lane_val[l] = {1'b0, dv_last.quo[l]};
            end
        end
        case (dv_last.rsel)
            COMP_X:
            begin
                comp_val = {lane_val[2], lane_val[1], lane_val[0], dv_last.half};
            end
            COMP_Y:
            begin
                comp_val = {lane_val[2], lane_val[1], dv_last.half, lane_val[0]};
            end
            COMP_Z:
            begin
                comp_val = {lane_val[2], dv_last.half, lane_val[1], lane_val[0]};
            end
            default:
            begin
                comp_val = {dv_last.half, lane_val[2], lane_val[1], lane_val[0]};
            end
        endcase
        out_next = comp_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign quat_valid = out_valid_reg;
    assign quat_x     = out_reg[COMP_X];
    assign quat_y     = out_reg[COMP_Y];
    assign quat_z     = out_reg[COMP_Z];
    assign quat_w     = out_reg[COMP_W];

    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        (quat_valid && quat_stall) |-> stall)
        else $error("input taken while result stalled");

    a_root_to_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_last.valid && !stall) |=> dv_entry_reg.valid)
        else $error("item lost between root and divider");

    a_divider_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_last.valid && !stall) |=> quat_valid)
        else $error("item lost at output register");

endmodule

### hdl/rmq_prep.sv
// rmq_prep: input stage; trace, branch select, radicand and numerators.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_prep
    import rmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] m00,
    input  logic signed [DW-1:0] m01,
    input  logic signed [DW-1:0] m02,
    input  logic signed [DW-1:0] m10,
    input  logic signed [DW-1:0] m11,
    input  logic signed [DW-1:0] m12,
    input  logic signed [DW-1:0] m20,
    input  logic signed [DW-1:0] m21,
    input  logic signed [DW-1:0] m22,
    output rmq_sq_t              dout
);

    typedef logic signed [XW-1:0] ext_t;
    localparam ext_t ONE_X = ext_t'(XW'(1) << FW);

    ext_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
    ext_t tr, rad_s, mii, mjj, mkk;
    ext_t n0, n1, n2;
    logic [RADW-1:0] rad;
    comp_t rsel;
    rmq_sq_t dout_reg, dout_next;

    always_comb
    begin
        e00 = ext_t'(m00);
        e01 = ext_t'(m01);
        e02 = ext_t'(m02);
        e10 = ext_t'(m10);
        e11 = ext_t'(m11);
        e12 = ext_t'(m12);
        e20 = ext_t'(m20);
        e21 = ext_t'(m21);
        e22 = ext_t'(m22);
        tr  = e00 + e11 + e22;

        // strict compares pick the largest diagonal entry; a positive trace picks W
        if (e22 > ((e11 > e00) ? e11 : e00))
        begin
            rsel = COMP_Z;
        end
        else if (e11 > e00)
        begin
            rsel = COMP_Y;
        end
        else
        begin
            rsel = COMP_X;
        end
        if (tr > ext_t'(0))
        begin
            rsel = COMP_W;
        end

        case (rsel)
            COMP_X:
            begin
                mii = e00; mjj = e11; mkk = e22;
                n0 = e01 + e10; n1 = e02 + e20; n2 = e12 - e21;
            end
            COMP_Y:
            begin
                mii = e11; mjj = e22; mkk = e00;
                n0 = e10 + e01; n1 = e12 + e21; n2 = e20 - e02;
            end
            COMP_Z:
            begin
                mii = e22; mjj = e00; mkk = e11;
                n0 = e20 + e02; n1 = e21 + e12; n2 = e01 - e10;
            end
            default:
            begin
                mii = tr; mjj = ext_t'(0); mkk = ext_t'(0);
                n0 = e12 - e21; n1 = e20 - e02; n2 = e01 - e10;
            end
        endcase

        rad_s = mii - mjj - mkk + ONE_X;
        rad   = rad_s[XW-1] ? '0 : rad_s[RADW-1:0];

        dout_next.valid        = in_valid;
        dout_next.bits         = {1'b0, rad, {FW{1'b0}}};
        dout_next.rem          = '0;
        dout_next.root         = '0;
        dout_next.meta.rsel    = rsel;
        dout_next.meta.num[0]  = n0[NW-1:0];
        dout_next.meta.num[1]  = n1[NW-1:0];
        dout_next.meta.num[2]  = n2[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

### hdl/rmq_sqrt_cell.sv
// rmq_sqrt_cell: one root digit per cell, restoring square root.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt_cell
    import rmq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  rmq_sq_t din,
    output rmq_sq_t dout
);

    logic [REMW+1:0] rem2, trial, diff;
    rmq_sq_t dout_reg, dout_next;

    always_comb
    begin
        dout_next      = din;
        rem2           = {din.rem, din.bits[NBITS-1 -: 2]};
        trial          = {{(REMW-SW){1'b0}}, din.root, 2'b01};
        diff           = rem2 - trial;
        dout_next.bits = {din.bits[NBITS-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            dout_next.rem  = diff[REMW-1:0];
            dout_next.root = {din.root[SW-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem  = rem2[REMW-1:0];
            dout_next.root = {din.root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

### hdl/rmq_div_cell.sv
// rmq_div_cell: one quotient bit per cell for each of the three lanes.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div_cell
    import rmq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  rmq_dv_t din,
    output rmq_dv_t dout
);

    logic [LANES-1:0][DVW:0] rem2;
    logic [LANES-1:0][DVW:0] diff;
    rmq_dv_t dout_reg, dout_next;

    always_comb
    begin
        dout_next = din;
        for (int l = 0; l < LANES; l++)
        begin
            rem2[l] = {din.rem[l], din.nb[l]};
            diff[l] = rem2[l] - {1'b0, din.dvs};
            if (rem2[l] >= {1'b0, din.dvs})
            begin
                dout_next.rem[l] = diff[l][DVW-1:0];
                dout_next.quo[l] = {din.quo[l][QW-2:0], 1'b1};
            end
            else
            begin
                dout_next.rem[l] = rem2[l][DVW-1:0];
                dout_next.quo[l] = {din.quo[l][QW-2:0], 1'b0};
            end
            dout_next.nb[l] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule
